// ----- src/scd_pkg.sv -----
// package for the streaming chunk deframer: chunk type codes, result kinds,
// parser phases and the result word struct; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

    localparam logic [15:0] TYPE_HEADER = 16'h4824;
    localparam logic [15:0] TYPE_DATA   = 16'h4424;
    localparam logic [15:0] TYPE_EOS    = 16'h4524;
    localparam logic [15:0] TYPE_CHANGE = 16'h4324;

    // extra header bytes after type and size
    localparam logic [3:0]  FULL_EXTRA  = 4'd8;
    localparam logic [15:0] SIZE2_BIAS  = 16'd8;
    localparam logic [3:0]  FIXED_LEN   = 4'd4;

    // byte positions inside the chunk header, counted from the first type byte
    localparam logic [3:0]  POS_SIZE2_LO = 4'd10;
    localparam logic [3:0]  POS_SIZE2_HI = 4'd11;

    typedef enum logic [1:0] {
        PH_FIXED   = 2'd0,
        PH_EXTRA   = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_DATA   = 3'd1,
        KIND_EOS    = 3'd2,
        KIND_NEXT   = 3'd3,
        KIND_CHANGE = 3'd4,
        KIND_BAD    = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic        last;
        logic [15:0] pad_count;
        logic [31:0] chunk_sequence;
    } t_result;

endpackage

`default_nettype wire

// ----- src/scd_in_reg.sv -----
// input register for the raw byte stream; holds one word while the parser waits
// depends on nothing but the clock and reset
`timescale 1ns / 1ps
`default_nettype none

module scd_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_stall,
    input  wire logic       i_take,
    output logic            o_full,
    output logic [7:0]      o_byte
);

    logic       r_full;
    logic       n_full;
    logic [7:0] r_byte;
    logic       w_accept;

    // the held word can leave in the same cycle a new one arrives
    assign o_stall  = r_full && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_full = r_full;
        if (w_accept) begin
            n_full = 1'b1;
        end else if (i_take) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_full = r_full;
    assign o_byte = r_byte;

endmodule

`default_nettype wire

// ----- src/scd_parser.sv -----
// chunk header parser and payload counter; one byte per step
// depends on scd_pkg
`timescale 1ns / 1ps
`default_nettype none

module scd_parser
    import scd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_byte,
    input  wire logic [15:0] i_min_packet_size,
    output logic             o_res_valid,
    output t_result          o_res
);

    t_phase      r_phase,   n_phase;
    logic [3:0]  r_hidx,    n_hidx;
    logic [3:0]  r_ehl,     n_ehl;
    logic [15:0] r_type,    n_type;
    logic [7:0]  r_size_lo, n_size_lo;
    logic [31:0] r_seq,     n_seq;
    logic [15:0] r_ss,      n_ss;
    logic [15:0] r_left,    n_left;
    logic [15:0] r_total,   n_total;
    logic        r_halted,  n_halted;

    logic        w_done;
    logic [15:0] w_size;
    logic [3:0]  w_hi;
    logic [15:0] w_len;
    logic        w_is_hdr;

    always_comb begin
        n_phase   = r_phase;
        n_hidx    = r_hidx;
        n_ehl     = r_ehl;
        n_type    = r_type;
        n_size_lo = r_size_lo;
        n_seq     = r_seq;
        n_ss      = r_ss;
        n_left    = r_left;
        n_total   = r_total;
        n_halted  = r_halted;
        w_done    = 1'b0;
        w_size    = {i_byte, r_size_lo};
        w_hi      = r_hidx + 4'd1;
        w_len     = '0;
        w_is_hdr  = (r_type == TYPE_HEADER);
        o_res_valid          = 1'b0;
        o_res.kind           = KIND_HEADER;
        o_res.data_byte      = '0;
        o_res.last           = 1'b0;
        o_res.pad_count      = '0;
        o_res.chunk_sequence = '0;

        if (i_step && !r_halted) begin
            unique case (r_phase)
                PH_FIXED: begin
                    n_hidx = {2'b00, r_hidx[1:0]} + 4'd1;
                    unique case (r_hidx[1:0])
                        2'd0: n_type[7:0]  = i_byte;
                        2'd1: n_type[15:8] = i_byte;
                        2'd2: n_size_lo    = i_byte;
                        2'd3: begin
                            n_ehl = (w_size > {12'd0, FULL_EXTRA}) ? FULL_EXTRA
                                                                   : w_size[3:0];
                            if (n_ehl == 4'd0) begin
                                w_done = 1'b1;
                            end else begin
                                n_phase = PH_EXTRA;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_EXTRA: begin
                    if (r_hidx[3:2] == 2'b01) begin
                        // sequence bytes, little endian
                        n_seq[{r_hidx[1:0], 3'b000} +: 8] = i_byte;
                    end else if (r_hidx == POS_SIZE2_LO) begin
                        n_ss[7:0] = i_byte;
                    end else if (r_hidx == POS_SIZE2_HI) begin
                        n_ss[15:8] = i_byte;
                    end
                    n_hidx = w_hi;
                    if (({1'b0, w_hi} >= ({1'b0, FIXED_LEN} + {1'b0, r_ehl}))
                            || (w_hi < FIXED_LEN)) begin
                        w_done = 1'b1;
                    end
                end
                default: begin
                    n_left = r_left - 16'd1;
                    o_res_valid     = 1'b1;
                    o_res.kind      = w_is_hdr ? KIND_HEADER : KIND_DATA;
                    o_res.data_byte = i_byte;
                    if (n_left == 16'd0) begin
                        o_res.last = 1'b1;
                        n_phase    = PH_FIXED;
                        n_hidx     = '0;
                        if (!w_is_hdr && (r_total < i_min_packet_size)) begin
                            o_res.pad_count = i_min_packet_size - r_total;
                        end
                    end
                end
            endcase

            if (w_done) begin
                n_phase = PH_FIXED;
                n_hidx  = '0;
                // short extra header counts as an empty payload
                if (n_ehl < FULL_EXTRA) begin
                    n_ss = SIZE2_BIAS;
                end
                if (n_type == TYPE_EOS) begin
                    o_res_valid = 1'b1;
                    o_res.last  = 1'b1;
                    if (n_seq == 32'd0) begin
                        o_res.kind = KIND_EOS;
                        n_halted   = 1'b1;
                    end else begin
                        o_res.kind = KIND_NEXT;
                    end
                end else if (n_type == TYPE_CHANGE) begin
                    o_res_valid = 1'b1;
                    o_res.last  = 1'b1;
                    o_res.kind  = KIND_CHANGE;
                end else if (n_type != TYPE_HEADER && n_type != TYPE_DATA) begin
                    o_res_valid = 1'b1;
                    o_res.last  = 1'b1;
                    o_res.kind  = KIND_BAD;
                    n_halted    = 1'b1;
                end else begin
                    w_len = (n_ss >= SIZE2_BIAS) ? (n_ss - SIZE2_BIAS) : 16'd0;
                    if (w_len != 16'd0) begin
                        n_phase = PH_PAYLOAD;
                        n_left  = w_len;
                        n_total = w_len;
                    end
                end
            end
        end

        o_res.chunk_sequence = n_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FIXED;
            r_hidx    <= '0;
            r_ehl     <= '0;
            r_type    <= '0;
            r_size_lo <= '0;
            r_seq     <= '0;
            r_ss      <= '0;
            r_left    <= '0;
            r_total   <= '0;
            r_halted  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hidx    <= n_hidx;
            r_ehl     <= n_ehl;
            r_type    <= n_type;
            r_size_lo <= n_size_lo;
            r_seq     <= n_seq;
            r_ss      <= n_ss;
            r_left    <= n_left;
            r_total   <= n_total;
            r_halted  <= n_halted;
        end
    end

endmodule

`default_nettype wire

// ----- src/scd_out_reg.sv -----
// result register; holds one result word until the sink takes it
// depends on scd_pkg
`timescale 1ns / 1ps
`default_nettype none

module scd_out_reg
    import scd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  t_result      i_res,
    input  wire logic    i_stall,
    output logic         o_free,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // free when empty or when the word held leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_free) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ----- src/streaming_chunk_deframer_core.sv -----
// top level of the streaming chunk deframer: input register, parser, result register
// depends on scd_pkg, scd_in_reg, scd_parser, scd_out_reg
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_rx_byte
//   result    out        o_valid / i_stall   o_kind o_data_byte o_last o_pad_count
//                                            o_chunk_sequence
//   config    in         i_cfg_wr_en         i_cfg_wr_data (min_packet_size)
//
// one word per cycle sustained unless the sink stalls; a byte waits in the input
// register until parsed, and its result, if any, appears on the cycle after parsing
// reset is synchronous and active low and clears the parser and both valid flags
// a stalled result holds the parser; the input register still takes one more word
// after end of stream with sequence zero or a bad chunk, words are taken and dropped
`timescale 1ns / 1ps
`default_nettype none

module streaming_chunk_deframer_core
    import scd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic             o_last,
    output logic [15:0]      o_pad_count,
    output logic [31:0]      o_chunk_sequence,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);

    logic [15:0] r_min_packet_size;
    logic        w_full;
    logic [7:0]  w_byte;
    logic        w_free;
    logic        w_step;
    logic        w_res_valid;
    t_result     w_res;
    t_result     w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_packet_size <= '0;
        end else if (i_cfg_wr_en) begin
            r_min_packet_size <= i_cfg_wr_data;
        end
    end

    assign w_step = w_full && w_free;

    scd_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_take    (w_step),
        .o_full    (w_full),
        .o_byte    (w_byte)
    );

    scd_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_step),
        .i_byte            (w_byte),
        .i_min_packet_size (r_min_packet_size),
        .o_res_valid       (w_res_valid),
        .o_res             (w_res)
    );

    scd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step && w_res_valid),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_free  (w_free),
        .o_valid (o_valid),
        .o_res   (w_out)
    );

    assign o_kind           = w_out.kind;
    assign o_data_byte      = w_out.data_byte;
    assign o_last           = w_out.last;
    assign o_pad_count      = w_out.pad_count;
    assign o_chunk_sequence = w_out.chunk_sequence;

endmodule

`default_nettype wire

// ----- src/scd_checker.sv -----
// port-level checks for the streaming chunk deframer, bound to the top level
// depends on scd_pkg and streaming_chunk_deframer_core
`timescale 1ns / 1ps
`default_nettype none

module scd_checker
    import scd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_kind,
    input wire logic [7:0]  o_data_byte,
    input wire logic        o_last,
    input wire logic [15:0] o_pad_count,
    input wire logic [31:0] o_chunk_sequence
);

    logic w_notice;
    logic w_halt_word;

    assign w_notice    = (o_kind == KIND_EOS) || (o_kind == KIND_NEXT)
                      || (o_kind == KIND_CHANGE) || (o_kind == KIND_BAD);
    assign w_halt_word = (o_kind == KIND_EOS) || (o_kind == KIND_BAD);

    // notices carry no byte and always close
    a_notice_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && w_notice) |-> (o_last && (o_data_byte == 8'd0)
                                   && (o_pad_count == 16'd0)))
        else $error("notice word with byte, pad or without last");

    // padding only on the closing byte of a data chunk
    a_pad_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_pad_count != 16'd0)) |-> (o_last && (o_kind == KIND_DATA)))
        else $error("pad count outside last data byte");

    // end of stream or bad chunk is the final word
    a_halt_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && w_halt_word) |=> !o_valid)
        else $error("word after halting notice");

    // end of stream only with zero sequence, next stream only with nonzero
    a_eos_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_kind == KIND_EOS) || (o_kind == KIND_NEXT)))
            |-> ((o_kind == KIND_EOS) == (o_chunk_sequence == 32'd0)))
        else $error("end of stream kind disagrees with sequence");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kind) && $stable(o_data_byte)
                                  && $stable(o_chunk_sequence)))
        else $error("stalled word changed");

endmodule

bind streaming_chunk_deframer_core scd_checker u_scd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_kind           (o_kind),
    .o_data_byte      (o_data_byte),
    .o_last           (o_last),
    .o_pad_count      (o_pad_count),
    .o_chunk_sequence (o_chunk_sequence)
);

`default_nettype wire
